[src/frq_pkg.sv]
// Shared types, constants and codes for the FIFO run queue scheduler.
package frq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int MAX_RESULTS = 32;
    localparam int ID_W        = 6;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int QCOUNT_W    = 7;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STEAL_W     = $clog2(MAX_RESULTS + 1);
    localparam int CMP_W       = (CNT_W > STEAL_W) ? CNT_W : STEAL_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_ROTATE  = 3'd2,
        CMD_PICK    = 3'd3,
        CMD_STEAL   = 3'd4,
        CMD_SET_RUN = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_ABSENT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_FIND,
        ST_APPLY,
        ST_STEAL
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_MATCH,
        CELL_ENQ,
        CELL_REMOVE,
        CELL_ROTATE,
        CELL_SET_RUN,
        CELL_STEAL
    } cell_op_t;

    // Contents of one queue position.
    typedef struct packed {
        logic            valid;
        logic            runnable;
        logic [ID_W-1:0] id;
    } entry_t;

    // Broadcast control to every cell.
    typedef struct packed {
        cell_op_t        op;
        logic [ID_W-1:0] pid;
        logic            run;
        logic [ID_W-1:0] head_id;
        logic            head_run;
    } cell_ctrl_t;

    // What a cell sees of its neighbor toward the head.
    typedef struct packed {
        logic present;
        logic valid;
    } left_link_t;

endpackage

[src/frq_cell.sv]
// One queue position of the run queue cell chain.
module frq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  frq_pkg::cell_ctrl_t ctrl,
    input  frq_pkg::left_link_t left,
    input  frq_pkg::entry_t     right,
    input  logic                ge,
    output frq_pkg::entry_t     entry,
    output logic                hit
);
    import frq_pkg::*;

    logic            valid_reg, valid_next;
    logic            run_reg, run_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic            hit_reg, hit_next;

    always_comb
    begin
        valid_next = valid_reg;
        run_next   = run_reg;
        id_next    = id_reg;
        hit_next   = hit_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_MATCH:
            begin
                hit_next = valid_reg && (id_reg == ctrl.pid);
            end
            CELL_ENQ:
            begin
                if (!valid_reg && left.valid)
                begin
                    valid_next = 1'b1;
                    run_next   = ctrl.run;
                    id_next    = ctrl.pid;
                end
            end
            CELL_REMOVE:
            begin
                // Every position at or past the removed one pulls from the right.
                if (ge)
                begin
                    valid_next = right.valid;
                    run_next   = right.runnable;
                    id_next    = right.id;
                end
            end
            CELL_ROTATE:
            begin
                // The tail takes the old head, the rest move one toward the head.
                if (valid_reg)
                begin
                    if (!right.valid)
                    begin
                        run_next = ctrl.head_run;
                        id_next  = ctrl.head_id;
                    end
                    else
                    begin
                        run_next = right.runnable;
                        id_next  = right.id;
                    end
                end
            end
            CELL_SET_RUN:
            begin
                if (hit_reg)
                begin
                    run_next = ctrl.run;
                end
            end
            CELL_STEAL:
            begin
                // The head stays; everything behind it closes the gap.
                if (left.present)
                begin
                    valid_next = right.valid;
                    run_next   = right.runnable;
                    id_next    = right.id;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            run_reg   <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            run_reg   <= run_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign entry.valid    = valid_reg;
    assign entry.runnable = run_reg;
    assign entry.id       = id_reg;
    assign hit            = hit_reg;

endmodule

[src/fifo_run_queue_scheduler.sv]
// Top level of the FIFO run queue scheduler: sequencer, search logic and cell chain.
//
//   channel  | handshake    | beat fields
//   ---------+--------------+--------------------------------------------
//   command  | start, busy  | command, proc_id, runnable_in
//   result   | done         | status, id_out, id_valid, queue_count, last
//
// A command is taken at a rising edge with start high and busy low. Every
// command except steal half goes through these steps to its result beat:
// it is latched, every cell compares its id, the lowest-set-bit search runs
// over the hit or runnable vector (a single wide subtract), and the change
// is applied and the result registered. Steal half then sends one beat per
// stolen entry, since each beat shifts the cell chain by one position; its
// beats follow each other with no gap.
// Reset is asynchronous and active low and empties the queue at once.
// The receiver cannot stall: each result beat is on the ports for exactly
// one cycle, marked by done; a new command may start with the last beat.
module fifo_run_queue_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [frq_pkg::CMD_W-1:0]     command,
    input  logic [frq_pkg::ID_W-1:0]      proc_id,
    input  logic                          runnable_in,
    output logic                          done,
    output logic [frq_pkg::STATUS_W-1:0]  status,
    output logic [frq_pkg::ID_W-1:0]      id_out,
    output logic                          id_valid,
    output logic [frq_pkg::QCOUNT_W-1:0]  queue_count,
    output logic                          last
);
    import frq_pkg::*;

    // Sequencer state and the latched command.
    state_t           state_reg, state_next;
    cmd_t             cmd_reg;
    logic [ID_W-1:0]  pid_reg;
    logic             run_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [STEAL_W-1:0] left_reg, left_next;

    // Search results: positions at or past the first hit or runnable entry, and whether one exists.
    logic [QUEUE_DEPTH-1:0] ge_reg, ge_next;
    logic                   found_reg, found_next;

    // Result beat registers.
    logic            done_reg, done_next;
    status_t         status_reg, status_next;
    logic [ID_W-1:0] id_out_reg, id_out_next;
    logic            id_valid_reg, id_valid_next;
    logic            last_reg, last_next;

    // Cell chain.
    cell_ctrl_t             ctrl;
    cell_op_t               cell_op;
    entry_t                 entries [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] hit_vec;
    logic [QUEUE_DEPTH-1:0] valid_vec;
    logic [QUEUE_DEPTH-1:0] runq_vec;
    logic [QUEUE_DEPTH-1:0] search_vec;
    logic [QUEUE_DEPTH-1:0] sel_vec;
    logic [ID_W-1:0]        pick_id;
    logic [CNT_W-1:0]       half_cnt;
    logic [STEAL_W-1:0]     steal_n;
    logic                   accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            left_link_t lnk;
            entry_t     rgt;
            if (gi == 0)
            begin : g_head
                // The head has no neighbor on its left; it acts as if one were filled.
                assign lnk.present = 1'b0;
                assign lnk.valid   = 1'b1;
            end
            else
            begin : g_body
                assign lnk.present = 1'b1;
                assign lnk.valid   = entries[gi-1].valid;
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign rgt = '0;
            end
            else
            begin : g_mid
                assign rgt = entries[gi+1];
            end
            frq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .left  (lnk),
                .right (rgt),
                .ge    (ge_reg[gi]),
                .entry (entries[gi]),
                .hit   (hit_vec[gi])
            );
            assign valid_vec[gi] = entries[gi].valid;
            assign runq_vec[gi]  = entries[gi].valid && entries[gi].runnable;
        end
    endgenerate

    assign ctrl.op       = cell_op;
    assign ctrl.pid      = pid_reg;
    assign ctrl.run      = run_reg;
    assign ctrl.head_id  = entries[0].id;
    assign ctrl.head_run = entries[0].runnable;

    // Pick looks for the first runnable entry, the other commands for the first id match.
    // h | ~(h - 1) sets every bit at or above the lowest set bit of h, and none if h is zero.
    assign search_vec = (cmd_reg == CMD_PICK) ? runq_vec : hit_vec;
    assign ge_next    = search_vec | ~(search_vec - QUEUE_DEPTH'(1));
    assign found_next = |search_vec;

    // The one-hot first position is where the mask starts.
    assign sel_vec = ge_reg & ~{ge_reg[QUEUE_DEPTH-2:0], 1'b0};

    always_comb
    begin
        pick_id = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (sel_vec[i])
            begin
                pick_id = pick_id | entries[i].id;
            end
        end
    end

    // Steal takes floor(count / 2) entries, capped by the result limit.
    assign half_cnt = count_reg >> 1;
    assign steal_n  = (CMP_W'(half_cnt) > CMP_W'(MAX_RESULTS)) ?
                      STEAL_W'(MAX_RESULTS) : STEAL_W'(half_cnt);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_FIND;
            end
            ST_FIND:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if ((cmd_reg == CMD_STEAL) && (steal_n != '0))
                begin
                    state_next = ST_STEAL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_STEAL:
            begin
                if (left_reg == STEAL_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Cell operations, queue count and result beat.
    always_comb
    begin
        cell_op       = CELL_HOLD;
        count_next    = count_reg;
        left_next     = left_reg;
        done_next     = 1'b0;
        status_next   = STAT_EMPTY;
        id_out_next   = '0;
        id_valid_next = 1'b0;
        last_next     = 1'b1;
        unique case (state_reg)
            ST_IDLE, ST_FIND:
            begin
            end
            ST_MATCH:
            begin
                cell_op = CELL_MATCH;
            end
            ST_APPLY:
            begin
                done_next = 1'b1;
                unique case (cmd_reg)
                    CMD_ENQUEUE:
                    begin
                        if (count_reg < CNT_W'(QUEUE_DEPTH))
                        begin
                            cell_op     = CELL_ENQ;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = STAT_OK;
                        end
                        else
                        begin
                            status_next = STAT_FULL;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            cell_op     = CELL_REMOVE;
                            count_next  = count_reg - CNT_W'(1);
                            status_next = STAT_OK;
                        end
                        else
                        begin
                            status_next = STAT_ABSENT;
                        end
                    end
                    CMD_ROTATE:
                    begin
                        if (count_reg != '0)
                        begin
                            cell_op     = CELL_ROTATE;
                            status_next = STAT_OK;
                        end
                    end
                    CMD_PICK:
                    begin
                        if (found_reg)
                        begin
                            status_next   = STAT_OK;
                            id_out_next   = pick_id;
                            id_valid_next = 1'b1;
                        end
                    end
                    CMD_STEAL:
                    begin
                        // The count drops to its final value now; each beat shows it.
                        if (steal_n != '0)
                        begin
                            done_next  = 1'b0;
                            left_next  = steal_n;
                            count_next = CNT_W'(CMP_W'(count_reg) - CMP_W'(steal_n));
                        end
                    end
                    CMD_SET_RUN:
                    begin
                        if (found_reg)
                        begin
                            cell_op     = CELL_SET_RUN;
                            status_next = STAT_OK;
                        end
                        else
                        begin
                            status_next = STAT_ABSENT;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_EMPTY;
                    end
                endcase
            end
            ST_STEAL:
            begin
                // The entry right after the head leaves on this beat.
                cell_op       = CELL_STEAL;
                done_next     = 1'b1;
                status_next   = STAT_OK;
                id_out_next   = entries[1].id;
                id_valid_next = 1'b1;
                last_next     = (left_reg == STEAL_W'(1));
                left_next     = left_reg - STEAL_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            left_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(command);
            pid_reg <= proc_id;
            run_reg <= runnable_in;
        end
        if (state_reg == ST_FIND)
        begin
            ge_reg    <= ge_next;
            found_reg <= found_next;
        end
        status_reg   <= status_next;
        id_out_reg   <= id_out_next;
        id_valid_reg <= id_valid_next;
        last_reg     <= last_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign id_out      = id_out_reg;
    assign id_valid    = id_valid_reg;
    assign queue_count = QCOUNT_W'(count_reg);
    assign last        = last_reg;

    // The filled cells always match the count, except while a steal is draining.
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_STEAL) |-> ($countones(valid_vec) == count_reg))
        else $error("filled cells disagree with queue count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // Steal beats follow each other without a gap until the last one.
    a_steal_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !last_reg) |=> done_reg)
        else $error("gap inside a steal burst");

    a_id_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && id_valid_reg) |-> (status_reg == STAT_OK))
        else $error("id presented with a failing status");

    // A beat that is not the last comes only from the steal drain.
    a_nonlast_is_steal: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !last_reg) |-> (state_reg == ST_STEAL))
        else $error("non-final beat outside a steal");

endmodule

[tb/run_queue_checker.sv]
// Checker for the FIFO run queue scheduler: predicts the result beats and compares them.
module run_queue_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [frq_pkg::CMD_W-1:0]     command,
    input  logic [frq_pkg::ID_W-1:0]      proc_id,
    input  logic                          runnable_in,
    input  logic                          done,
    input  logic [frq_pkg::STATUS_W-1:0]  status,
    input  logic [frq_pkg::ID_W-1:0]      id_out,
    input  logic                          id_valid,
    input  logic [frq_pkg::QCOUNT_W-1:0]  queue_count,
    input  logic                          last,
    output int                            errors_seen,
    output int                            beats_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import frq_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [ID_W-1:0]     id;
        logic                id_valid;
        logic [QCOUNT_W-1:0] count;
        logic                last;
    } result_beat_t;

    result_beat_t    owed_beats [$];
    logic [ID_W-1:0] shadow_ids [QUEUE_DEPTH];
    logic            shadow_run [QUEUE_DEPTH];
    int              shadow_len;

    task automatic drop_entry(input int pos);
        for (int i = pos; i + 1 < shadow_len; i++)
        begin
            shadow_ids[i] = shadow_ids[i + 1];
            shadow_run[i] = shadow_run[i + 1];
        end
        shadow_len--;
    endtask

    // Applies one command beat to the shadow queue and queues the beats it must produce.
    task automatic predict_queue_step(input logic [CMD_W-1:0] cmd,
                                      input logic [ID_W-1:0] pid, input logic run);
        status_t         st;
        logic [ID_W-1:0] picked;
        logic            picked_ok;
        int              hit;
        int              n;
        logic [ID_W-1:0] head_id;
        logic            head_run;
        logic [ID_W-1:0] stolen [$];
        result_beat_t    beat;
        st        = STAT_EMPTY;
        picked    = '0;
        picked_ok = 1'b0;
        hit       = -1;
        case (cmd)
            CMD_ENQUEUE:
            begin
                if (shadow_len >= QUEUE_DEPTH)
                    st = STAT_FULL;
                else
                begin
                    shadow_ids[shadow_len] = pid;
                    shadow_run[shadow_len] = run;
                    shadow_len++;
                    st = STAT_OK;
                end
            end
            CMD_REMOVE:
            begin
                st = STAT_ABSENT;
                for (int i = 0; i < shadow_len; i++)
                    if (hit < 0 && shadow_ids[i] == pid)
                        hit = i;
                if (hit >= 0)
                begin
                    drop_entry(hit);
                    st = STAT_OK;
                end
            end
            CMD_ROTATE:
            begin
                if (shadow_len != 0)
                begin
                    head_id  = shadow_ids[0];
                    head_run = shadow_run[0];
                    for (int i = 0; i + 1 < shadow_len; i++)
                    begin
                        shadow_ids[i] = shadow_ids[i + 1];
                        shadow_run[i] = shadow_run[i + 1];
                    end
                    shadow_ids[shadow_len - 1] = head_id;
                    shadow_run[shadow_len - 1] = head_run;
                    st = STAT_OK;
                end
            end
            CMD_PICK:
            begin
                for (int i = 0; i < shadow_len; i++)
                    if (!picked_ok && shadow_run[i])
                    begin
                        picked    = shadow_ids[i];
                        picked_ok = 1'b1;
                        st        = STAT_OK;
                    end
            end
            CMD_STEAL:
            begin
                n = shadow_len / 2;
                if (n > MAX_RESULTS)
                    n = MAX_RESULTS;
                for (int k = 0; k < n; k++)
                begin
                    stolen.push_back(shadow_ids[1]);
                    drop_entry(1);
                end
            end
            CMD_SET_RUN:
            begin
                st = STAT_ABSENT;
                for (int i = 0; i < shadow_len; i++)
                    if (shadow_ids[i] == pid)
                    begin
                        shadow_run[i] = run;
                        st = STAT_OK;
                    end
            end
            default:
                st = STAT_EMPTY;
        endcase

        if (stolen.size() != 0)
        begin
            foreach (stolen[k])
            begin
                beat.status   = STAT_OK;
                beat.id       = stolen[k];
                beat.id_valid = 1'b1;
                beat.count    = QCOUNT_W'(shadow_len);
                beat.last     = (k == stolen.size() - 1);
                owed_beats.push_back(beat);
            end
        end
        else
        begin
            beat.status   = st;
            beat.id       = picked;
            beat.id_valid = picked_ok;
            beat.count    = QCOUNT_W'(shadow_len);
            beat.last     = 1'b1;
            owed_beats.push_back(beat);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_beat_t want;
        if (!rst_n)
        begin
            owed_beats.delete();
            for (int i = 0; i < QUEUE_DEPTH; i++)
                shadow_run[i] = 1'b0;
            shadow_len = 0;
        end
        else
        begin
            // A result beat leaving the block is matched before a command taken at the same edge.
            if (done)
            begin
                if (owed_beats.size() == 0)
                begin
                    $error("result beat arrived with nothing expected");
                    errors_seen = errors_seen + 1;
                end
                else
                begin
                    want = owed_beats.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors_seen = errors_seen + 1;
                    end
                    if (id_out !== want.id)
                    begin
                        $error("id_out: expected %0d, got %0d", want.id, id_out);
                        errors_seen = errors_seen + 1;
                    end
                    if (id_valid !== want.id_valid)
                    begin
                        $error("id_valid: expected %0d, got %0d", want.id_valid, id_valid);
                        errors_seen = errors_seen + 1;
                    end
                    if (queue_count !== want.count)
                    begin
                        $error("queue_count: expected %0d, got %0d", want.count, queue_count);
                        errors_seen = errors_seen + 1;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        errors_seen = errors_seen + 1;
                    end
                end
            end
            if (start && !busy)
                predict_queue_step(command, proc_id, runnable_in);
        end
        beats_owed = owed_beats.size();
    end

endmodule

[tb/tb.sv]
// Top of the testbench: clock, reset, command stimulus and the final verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frq_pkg::*;

    // Codes 6 and 7 are not decoded by the block; each must still answer with one
    // beat that reports nothing found.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     command;
    logic [ID_W-1:0]      proc_id;
    logic                 runnable_in;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      id_out;
    logic                 id_valid;
    logic [QCOUNT_W-1:0]  queue_count;
    logic                 last;
    int                   errors_seen;
    int                   beats_owed;

    fifo_run_queue_scheduler uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .proc_id     (proc_id),
        .runnable_in (runnable_in),
        .done        (done),
        .status      (status),
        .id_out      (id_out),
        .id_valid    (id_valid),
        .queue_count (queue_count),
        .last        (last)
    );

    // The checker sees the same ports as the block and keeps its own copy of the queue.
    run_queue_checker queue_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .proc_id     (proc_id),
        .runnable_in (runnable_in),
        .done        (done),
        .status      (status),
        .id_out      (id_out),
        .id_valid    (id_valid),
        .queue_count (queue_count),
        .last        (last),
        .errors_seen (errors_seen),
        .beats_owed  (beats_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Presents one command beat and holds it until the block takes it. The caller
    // is at a falling edge; the task returns at the falling edge after acceptance
    // with start still high, so a burst keeps start asserted from beat to beat.
    // Busy is read right after the rising edge, which gives its value before that edge.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] pid,
                         input logic run);
        start       = 1'b1;
        command     = cmd;
        proc_id     = pid;
        runnable_in = run;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Lowers start for a number of cycles and lets the command fields wander,
    // since the block must ignore them while start is low.
    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            start       = 1'b0;
            command     = CMD_W'($urandom_range(0, 7));
            proc_id     = ID_W'($urandom);
            runnable_in = 1'($urandom);
            @(negedge clk);
        end
    endtask

    // Waits with start low until every predicted beat has come back.
    task automatic drain_results();
        start = 1'b0;
        while (beats_owed != 0)
            @(negedge clk);
    endtask

    // Most ids come from a small pool so that removes and runnable updates find
    // their targets and duplicates pile up; the rest cover the whole id range.
    function automatic logic [ID_W-1:0] random_id();
        if ($urandom_range(0, 99) < 75)
            return ID_W'($urandom_range(0, 15));
        return ID_W'($urandom_range(0, 63));
    endfunction

    // Chooses a command by phase weights: enqueue and steal half get their own
    // share, the rest is split among the other commands with a rare spare code.
    function automatic logic [CMD_W-1:0] random_command(input int enq_pct, input int steal_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < enq_pct)
            return CMD_ENQUEUE;
        if (roll < enq_pct + steal_pct)
            return CMD_STEAL;
        case ($urandom_range(0, 20))
            0:       return CMD_SPARE_LO;
            1:       return CMD_SPARE_HI;
            2, 3, 4, 5, 6:     return CMD_REMOVE;
            7, 8, 9, 10:       return CMD_ROTATE;
            11, 12, 13, 14:    return CMD_PICK;
            default: return CMD_SET_RUN;
        endcase
    endfunction

    // Sends a phase of random commands in bursts of random length. Most bursts
    // end in a gap of random length, so that start falls and rises at every step
    // of the block's command sequence and during steal beats; some bursts run
    // straight into the next with no gap.
    task automatic random_phase(input int items, input int enq_pct, input int steal_pct);
        int left;
        int burst;
        left = items;
        while (left > 0)
        begin
            burst = $urandom_range(1, 8);
            if (burst > left)
                burst = left;
            repeat (burst)
                issue(random_command(enq_pct, steal_pct), random_id(), 1'($urandom));
            left = left - burst;
            if ($urandom_range(0, 3) != 0)
                hold_off($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = CMD_ENQUEUE;
        proc_id     = '0;
        runnable_in = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. First everything that an empty queue must refuse.
        issue(CMD_ROTATE,   6'd0,  1'b0);
        issue(CMD_PICK,     6'd0,  1'b0);
        issue(CMD_STEAL,    6'd0,  1'b0);
        issue(CMD_REMOVE,   6'd5,  1'b0);
        issue(CMD_SET_RUN,  6'd5,  1'b1);
        issue(CMD_SPARE_LO, 6'd63, 1'b1);
        issue(CMD_SPARE_HI, 6'd0,  1'b0);
        // A single entry: rotate keeps it, steal half finds nothing to take,
        // pick finds nothing runnable, and removing it empties the queue.
        issue(CMD_ENQUEUE,  6'd0,  1'b0);
        issue(CMD_ROTATE,   6'd0,  1'b0);
        issue(CMD_STEAL,    6'd0,  1'b0);
        issue(CMD_PICK,     6'd0,  1'b0);
        issue(CMD_REMOVE,   6'd0,  1'b0);
        // Duplicate ids: set runnable marks both copies, remove takes the one
        // nearest the head.
        issue(CMD_ENQUEUE,  6'd63, 1'b1);
        issue(CMD_ENQUEUE,  6'd0,  1'b0);
        issue(CMD_ENQUEUE,  6'd63, 1'b0);
        issue(CMD_ENQUEUE,  6'd42, 1'b1);
        issue(CMD_PICK,     6'd0,  1'b0);
        issue(CMD_SET_RUN,  6'd63, 1'b0);
        issue(CMD_PICK,     6'd0,  1'b0);
        issue(CMD_ROTATE,   6'd0,  1'b0);
        issue(CMD_REMOVE,   6'd63, 1'b0);
        issue(CMD_STEAL,    6'd0,  1'b0);
        issue(CMD_ENQUEUE,  6'd21, 1'b1);
        issue(CMD_STEAL,    6'd0,  1'b0);

        // The sender stops here until the block has answered everything.
        drain_results();
        hold_off($urandom_range(0, 3));

        // Fill phase: mostly enqueues with no steals, enough to reach a full
        // queue and run into the full status several times.
        random_phase(90, 85, 0);
        drain_results();
        // A full queue gives up its maximum number of entries in one steal.
        issue(CMD_STEAL, random_id(), 1'($urandom));

        // Mixed phase, then a drain phase heavy on steals and removes that
        // brings the queue back toward empty.
        random_phase(100, 45, 8);
        random_phase(40, 10, 25);

        // Wait out the last beats, then allow the longest steal sequence in
        // case the block sends more than it should.
        drain_results();
        repeat (MAX_RESULTS + 8)
            @(negedge clk);
        if (errors_seen == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard limit far above the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
